// File: hdl/vdms_pkg.sv
// ----------------------------------------------------------------------------
// vdms_pkg: shared types and constants for the vertical drag motion step
// Fixed point constants, register indexes, channel payloads and the divider
// operation types.
// ----------------------------------------------------------------------------
package vdms_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DRAG     = 3'd0,
    REG_MASS     = 3'd1,
    REG_INIT_VEL = 3'd2,
    REG_DT       = 3'd3,
    REG_INTERVAL = 3'd4
  } reg_idx_t;

  // g = 9.8 in Q16.16
  localparam logic [31:0] G_Q16 = 32'd642253;
  localparam logic [31:0] ONE_Q16 = 32'd65536;
  localparam logic [31:0] DIV_MS = 32'd65536000;
  localparam logic [31:0] DIV_TRAP = 32'd131072000;

  localparam int unsigned MagW = 64;   // operand magnitude width

  // one input transfer: a single restart flag
  typedef struct packed {
    logic restart;
  } step_in_t;

  // one output transfer
  typedef struct packed {
    logic [31:0]        step_index;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic signed [31:0] step_displacement;
    logic signed [47:0] total_displacement;
    logic signed [47:0] total_impulse;
    logic signed [31:0] step_work;
    logic signed [47:0] total_work;
  } sample_t;

  // request into the multiply-divide unit
  typedef struct packed {
    logic [MagW-1:0] a;
    logic [MagW-1:0] b;
    logic [31:0]     d;
    logic            neg;
  } umd_req_t;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [63:0] sat48(input logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return x;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

endpackage

// File: hdl/vdms_stream_if.sv
// ----------------------------------------------------------------------------
// vdms_stream_if: valid/ready channel
// Carries one payload of parameterized type between a source and a sink.
// ----------------------------------------------------------------------------
interface vdms_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/vdms_umd.sv
// ----------------------------------------------------------------------------
// vdms_umd: serial signed multiply, rounded divide
// round(|a|*|b|/d) half away from zero, capped at 2^63-1, sign applied.
// Multiply is shift-add one bit a cycle, divide is restoring one bit a cycle.
// ----------------------------------------------------------------------------
module vdms_umd (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  vdms_pkg::umd_req_t     req,
  output logic                   done,
  output logic signed [63:0]     result
);

  typedef enum logic [1:0] {IDLE, MUL, DIV, FIN} state_t;

  state_t          state;
  logic [127:0]    mcand_w; // a, shifted left per bit
  logic [63:0]     mplier;  // b, shifted right per bit
  logic [127:0]    acc;     // product, then dividend shift
  logic [32:0]     rem;
  logic [127:0]    quo;
  logic [31:0]     dvs;
  logic            neg;
  logic [6:0]      cnt;
  logic [7:0]      dcnt;
  logic [33:0]     trial;
  logic [63:0]     qmag;

  assign trial = {rem, acc[127]} - {2'b0, dvs};
  assign qmag = (quo[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : quo[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            mcand_w <= {64'b0, req.a};
            mplier <= req.b;
            dvs <= req.d;
            neg <= req.neg;
            acc <= '0;
            cnt <= '0;
            state <= MUL;
          end
        end
        MUL: begin
          if (mplier[0]) acc <= acc + mcand_w;
          mcand_w <= mcand_w << 1;
          mplier <= mplier >> 1;
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) state <= FIN;
        end
        FIN: begin
          // add half divisor for rounding, start division
          acc <= acc + {97'b0, dvs[31:1]};
          rem <= '0;
          quo <= '0;
          dcnt <= '0;
          state <= DIV;
        end
        DIV: begin
          if (!trial[33]) begin
            rem <= trial[32:0];
            quo <= {quo[126:0], 1'b1};
          end else begin
            rem <= {rem[31:0], acc[127]};
            quo <= {quo[126:0], 1'b0};
          end
          acc <= acc << 1;
          dcnt <= dcnt + 8'd1;
          if (dcnt == 8'd127) begin
            state <= IDLE;
            done <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign result = neg ? -$signed(qmag) : $signed(qmag);

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_done_from_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == DIV) else $error("done not after divide");
  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (result != 64'sh8000_0000_0000_0000)) else $error("cap broken");
`endif

endmodule

// File: hdl/vertical_drag_motion_step.sv
// ----------------------------------------------------------------------------
// vertical_drag_motion_step: Euler step of vertical motion with quadratic drag
// One restart transfer in, zero or one sample transfer out.
// ----------------------------------------------------------------------------
// Each accepted item runs eight rounded multiply-divide operations in order
// (weight, v^2, drag, acceleration, velocity change, displacement, impulse,
// work) through one bit-serial unit: a start, the shift-add multiply, a
// rounding step and the restoring divide each, then the result is handed
// back. The unit is the rate limit; one item is in work at a time. A
// finished sample sits in the output register while the next item is taken;
// the next step waits only if that sample is still untaken when it finishes.
// Configuration is read as each operation starts, so a write during a step
// can change that step; a new initial velocity takes effect at the next
// restart. No clearing pass after reset.
module vertical_drag_motion_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [vdms_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [vdms_pkg::CfgDataW-1:0] cfg_data,
  vdms_stream_if.sink                in_ch,
  vdms_stream_if.source              out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_WG, S_V2, S_FD, S_A, S_DV, S_DS, S_IMP, S_WK, S_END
  } state_t;

  state_t state;
  logic [30:0] drag_k, mass, dt, interval;
  logic signed [31:0] init_vel;
  logic signed [31:0] cur_v;
  logic signed [47:0] dsum, isum, wsum;
  logic [31:0] phase, count;
  logic signed [63:0] wg, v2, f, a, vn, ds, imp, wk;
  logic umd_start, umd_done;
  vdms_pkg::umd_req_t req;
  logic signed [63:0] umd_res;
  logic [31:0] m_eff;
  logic signed [63:0] v64, fd_s, fsum;
  logic [32:0] ph;
  logic emit;
  logic step_fin;

  vdms_umd u_umd (.clk, .rst, .start(umd_start), .req, .done(umd_done), .result(umd_res));

  assign m_eff = (mass == '0) ? 32'd1 : {1'b0, mass};
  assign v64 = 64'(cur_v);
  assign fd_s = vdms_pkg::sat48(umd_res);
  assign fsum = vdms_pkg::sat48((cur_v > 0) ? wg + fd_s : wg - fd_s);
  assign ph = ({1'b0, phase} + {2'b0, dt} > 33'hFFFF_FFFF) ? 33'hFFFF_FFFF
            : {1'b0, phase} + {2'b0, dt};
  assign in_ch.ready = (state == S_IDLE);

  // operand set for the operation of each state
  always_comb begin
    req = '0;
    unique case (state)
      S_WG: begin req.a = 64'(mass); req.b = 64'(vdms_pkg::G_Q16); req.d = vdms_pkg::ONE_Q16; end
      S_V2: begin req.a = vdms_pkg::mag(v64); req.b = vdms_pkg::mag(v64);
                  req.d = vdms_pkg::ONE_Q16; end
      S_FD: begin req.a = v2[63:0]; req.b = 64'(drag_k); req.d = vdms_pkg::ONE_Q16; end
      S_A:  begin req.a = vdms_pkg::mag(f); req.b = 64'(vdms_pkg::ONE_Q16); req.d = m_eff;
                  req.neg = f[63]; end
      S_DV: begin req.a = vdms_pkg::mag(a); req.b = 64'(dt); req.d = vdms_pkg::DIV_MS;
                  req.neg = a[63]; end
      S_DS: begin req.a = vdms_pkg::mag(v64 + vn); req.b = 64'(dt);
                  req.d = vdms_pkg::DIV_TRAP; req.neg = (v64 + vn) < 0; end
      S_IMP: begin req.a = vdms_pkg::mag(f); req.b = 64'(dt); req.d = vdms_pkg::DIV_MS;
                  req.neg = f[63]; end
      S_WK: begin req.a = vdms_pkg::mag(ds); req.b = vdms_pkg::mag(f);
                  req.d = vdms_pkg::ONE_Q16; req.neg = ds[63] != f[63]; end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_k <= '0; mass <= 31'd65536; init_vel <= '0; dt <= 31'd65536;
      interval <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vdms_pkg::REG_DRAG:     drag_k <= cfg_data[30:0];
        vdms_pkg::REG_MASS:     mass <= cfg_data[30:0];
        vdms_pkg::REG_INIT_VEL: init_vel <= cfg_data;
        vdms_pkg::REG_DT:       dt <= cfg_data[30:0];
        vdms_pkg::REG_INTERVAL: interval <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign emit = ph > {2'b0, interval};
  // step completes this cycle: output register free or being drained
  assign step_fin = (state == S_END) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; umd_start <= 1'b0; out_ch.valid <= 1'b0;
      cur_v <= '0; dsum <= '0; isum <= '0; wsum <= '0; phase <= '0; count <= '0;
    end else begin
      umd_start <= 1'b0;
      if (out_ch.valid && out_ch.ready && !(step_fin && emit)) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.data.restart) begin
              cur_v <= init_vel; dsum <= '0; isum <= '0; wsum <= '0;
              phase <= '0; count <= '0;
            end
            state <= S_WG; umd_start <= 1'b1;
          end
        end
        S_WG: if (umd_done) begin wg <= umd_res; state <= S_V2; umd_start <= 1'b1; end
        S_V2: if (umd_done) begin v2 <= umd_res; state <= S_FD; umd_start <= 1'b1; end
        S_FD: if (umd_done) begin f <= fsum; state <= S_A; umd_start <= 1'b1; end
        S_A:  if (umd_done) begin a <= vdms_pkg::sat32(umd_res); state <= S_DV;
                umd_start <= 1'b1; end
        S_DV: if (umd_done) begin vn <= vdms_pkg::sat32(v64 - umd_res); state <= S_DS;
                umd_start <= 1'b1; end
        S_DS: if (umd_done) begin ds <= vdms_pkg::sat32(umd_res); state <= S_IMP;
                umd_start <= 1'b1; end
        S_IMP: if (umd_done) begin imp <= vdms_pkg::sat32(umd_res); state <= S_WK;
                umd_start <= 1'b1; end
        S_WK: if (umd_done) begin wk <= vdms_pkg::sat32(umd_res); state <= S_END; end
        S_END: begin
          // wait for a stalled sample to drain before overwriting it
          if (step_fin) begin
            cur_v <= vn[31:0];
            dsum <= 48'(vdms_pkg::sat48(64'(dsum) + ds));
            isum <= 48'(vdms_pkg::sat48(64'(isum) + imp));
            wsum <= 48'(vdms_pkg::sat48(64'(wsum) + wk));
            count <= count + 32'd1;
            phase <= emit ? 32'(ph - {2'b0, interval}) : ph[31:0];
            if (emit) begin
              out_ch.valid <= 1'b1;
              out_ch.data.step_index <= count;
              out_ch.data.velocity <= vn[31:0];
              out_ch.data.acceleration <= a[31:0];
              out_ch.data.step_displacement <= ds[31:0];
              out_ch.data.total_displacement <= 48'(vdms_pkg::sat48(64'(dsum) + ds));
              out_ch.data.total_impulse <= 48'(vdms_pkg::sat48(64'(isum) + imp));
              out_ch.data.step_work <= wk[31:0];
              out_ch.data.total_work <= 48'(vdms_pkg::sat48(64'(wsum) + wk));
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_on_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> umd_start) else $error("no start");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_valid_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == S_END) else $error("stray valid");
`endif

endmodule

// File: sim/vertical_drag_motion_step_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertical_drag_motion_step_test: self-checking bench for the drag motion step
// Drives restart transfers under several register settings and idling modes,
// predicts each emitted sample in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module vertical_drag_motion_step_test;

  localparam logic [vdms_pkg::CfgIdxW-1:0] REG_UNUSED_LO = 3'd5; // indexes past the map
  localparam logic [vdms_pkg::CfgIdxW-1:0] REG_UNUSED_HI = 3'd7;
  localparam int unsigned SettleCycles = 2000;
  localparam int unsigned WatchdogLimit = 20000; // idle cycles before abort

  logic clk;
  logic rst;
  logic cfg_we;
  logic [vdms_pkg::CfgIdxW-1:0] cfg_idx;
  logic [vdms_pkg::CfgDataW-1:0] cfg_data;

  vdms_stream_if #(.payload_t(vdms_pkg::step_in_t)) in_ch ();
  vdms_stream_if #(.payload_t(vdms_pkg::sample_t)) out_ch ();

  vertical_drag_motion_step dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---- predictor copy of the registers and the motion state ----
  logic [30:0]        drag_k;
  logic [30:0]        mass;
  logic signed [31:0] vel_init;
  logic [30:0]        dt_ms;
  logic [30:0]        interval_ms;

  logic signed [63:0] vel_now;
  logic signed [63:0] disp_total;
  logic signed [63:0] imp_total;
  logic signed [63:0] work_total;
  logic [31:0]        phase_acc;
  logic [31:0]        step_cnt;

  vdms_pkg::sample_t expected_samples[$];

  int unsigned idle_pct;   // sender gap probability, percent
  int unsigned stall_pct;  // receiver stall probability, percent
  bit          failed;
  int unsigned quiet_cycles;

  // round(a*b/d), halves away from zero, capped at 2^63-1
  function automatic logic [63:0] mul_div_round(input logic [63:0] a, input logic [63:0] b,
                                                input logic [31:0] d);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + {96'd0, d >> 1};
    quo = prod / {96'd0, d};
    if (quo > 128'h7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
    return quo[63:0];
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic signed [63:0] signed_mul_div(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input logic [31:0] d);
    logic signed [63:0] q;
    q = mul_div_round(magnitude(a), magnitude(b), d);
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [63:0] clamp48(input logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return x;
  endfunction

  // advance the motion state by one accepted step; queue a sample if emitted
  task automatic advance_motion(input logic restart);
    logic [31:0]        m;
    logic signed [63:0] v, t, weight, drag, force_net, accel, v_next, ds, imp, wk;
    logic [63:0]        v_sq;
    logic [32:0]        ph;
    vdms_pkg::sample_t  s;
    if (restart) begin
      vel_now = 64'(vel_init);
      disp_total = 0;
      imp_total = 0;
      work_total = 0;
      phase_acc = 0;
      step_cnt = 0;
    end
    m = (mass == 0) ? 32'd1 : {1'b0, mass}; // zero mass acts as one LSB
    v = vel_now;
    t = {33'd0, dt_ms};
    weight = mul_div_round({33'd0, mass}, 64'(vdms_pkg::G_Q16), vdms_pkg::ONE_Q16);
    v_sq = mul_div_round(magnitude(v), magnitude(v), vdms_pkg::ONE_Q16);
    drag = clamp48(mul_div_round(v_sq, {33'd0, drag_k}, vdms_pkg::ONE_Q16));
    // drag adds to weight on the way up, opposes it on the way down
    force_net = clamp48(v > 0 ? weight + drag : weight - drag);
    accel = clamp32(signed_mul_div(force_net, 64'(vdms_pkg::ONE_Q16), m));
    v_next = clamp32(v - signed_mul_div(accel, t, vdms_pkg::DIV_MS));
    ds = clamp32(signed_mul_div(v + v_next, t, vdms_pkg::DIV_TRAP));
    imp = clamp32(signed_mul_div(force_net, t, vdms_pkg::DIV_MS));
    wk = clamp32(signed_mul_div(ds, force_net, vdms_pkg::ONE_Q16));

    vel_now = v_next;
    disp_total = clamp48(disp_total + ds);
    imp_total = clamp48(imp_total + imp);
    work_total = clamp48(work_total + wk);
    s.step_index = step_cnt;
    step_cnt = step_cnt + 32'd1;

    // phase saturates at 2^32-1 before the interval compare
    ph = {1'b0, phase_acc} + {2'd0, dt_ms};
    if (ph[32]) ph = 33'h0_FFFF_FFFF;
    if (ph <= {2'd0, interval_ms}) begin
      phase_acc = ph[31:0];
    end else begin
      phase_acc = ph[31:0] - {1'b0, interval_ms};
      s.velocity = v_next[31:0];
      s.acceleration = accel[31:0];
      s.step_displacement = ds[31:0];
      s.total_displacement = disp_total[47:0];
      s.total_impulse = imp_total[47:0];
      s.step_work = wk[31:0];
      s.total_work = work_total[47:0];
      expected_samples.push_back(s);
    end
  endtask

  // ---- driving ----
  task automatic write_reg(input logic [vdms_pkg::CfgIdxW-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    case (idx)
      vdms_pkg::REG_DRAG:     drag_k = value[30:0];
      vdms_pkg::REG_MASS:     mass = value[30:0];
      vdms_pkg::REG_INIT_VEL: vel_init = value;
      vdms_pkg::REG_DT:       dt_ms = value[30:0];
      vdms_pkg::REG_INTERVAL: interval_ms = value[30:0];
      default:      ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all five registers, top bit random on the 31-bit ones to exercise masking
  task automatic configure(input logic [30:0] k, input logic [30:0] m,
                           input logic [31:0] v0, input logic [30:0] dt,
                           input logic [30:0] intv);
    write_reg(vdms_pkg::REG_DRAG, {1'($urandom), k});
    write_reg(vdms_pkg::REG_MASS, {1'($urandom), m});
    write_reg(vdms_pkg::REG_INIT_VEL, v0);
    write_reg(vdms_pkg::REG_DT, {1'($urandom), dt});
    write_reg(vdms_pkg::REG_INTERVAL, {1'($urandom), intv});
    // out-of-map index must leave everything alone
    write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
    end_writes();
  endtask

  // one restart transfer; valid stays high on return so back-to-back works
  task automatic send_step(input logic restart);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    advance_motion(restart);
  endtask

  // drop valid, drain expected samples, then let a silent step finish
  task automatic drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned src, input int unsigned snk);
    idle_pct = src;
    stall_pct = snk;
  endtask

  // ---- tests ----
  task automatic test_reset_defaults();
    // registers at reset values: unit mass, dt = interval, so every second step emits
    set_idling(0, 0);
    for (int i = 0; i < 4; i++) send_step(i == 2);
    drain();
  endtask

  task automatic test_directed_extremes();
    set_idling(0, 0);
    // fast climb with heavy drag: drag force saturates
    configure(31'h7FFF_FFFF, 31'h1_0000, 32'h7FFF_FFFF, 31'h1_0000, 31'd0);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    drain();
    // steepest fall, smallest mass, largest step
    configure(31'h0_8000, 31'd1, 32'h8000_0000, 31'h7FFF_FFFF, 31'd0);
    send_step(1'b1);
    send_step(1'b0);
    drain();
    // zero mass taken as one LSB
    configure(31'h1_0000, 31'd0, 32'h0005_0000, 31'h2_0000, 31'h1_0000);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    drain();
    // zero step: only the count moves, and the phase never passes zero interval
    configure(31'h1_0000, 31'h7FFF_FFFF, 32'hFFFB_0000, 31'd0, 31'd0);
    send_step(1'b1);
    send_step(1'b0);
    drain();
    // interval at maximum, large step: phase runs near its ceiling
    configure(31'd0, 31'h4_0000, 32'h0001_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_step(i == 0);
    drain();
    // new initial velocity without restart must not apply until a restart
    configure(31'h0_4000, 31'h2_0000, 32'h0010_0000, 31'h1_0000, 31'd0);
    send_step(1'b1);
    drain();
    write_reg(vdms_pkg::REG_INIT_VEL, 32'hFF00_0000);
    end_writes();
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    drain();
  endtask

  task automatic random_settings();
    logic [30:0] k, m, dt, intv;
    k = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h4_0000));
    m = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h64_0000));
    dt = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h14_0000));
    // mostly emit every step, sometimes every few
    case ($urandom_range(3))
      0:       intv = 31'd0;
      1:       intv = 31'($urandom_range(0, dt));
      2:       intv = 31'(dt * $urandom_range(1, 3));
      default: intv = 31'($urandom);
    endcase
    configure(k, m, $urandom, dt, intv);
  endtask

  task automatic test_random_motion(input int unsigned src, input int unsigned snk,
                                    input int unsigned steps);
    set_idling(src, snk);
    random_settings();
    send_step(1'b1);
    for (int i = 1; i < steps; i++) send_step($urandom_range(9) == 0);
    drain();
  endtask

  // ---- sample check ----
  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      failed = 1'b1;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        failed = 1'b1;
        $display("%0t unexpected sample: expected none actual %h", $time, out_ch.data);
      end else begin
        vdms_pkg::sample_t want;
        want = expected_samples.pop_front();
        check_field("step_index", 48'(want.step_index), 48'(out_ch.data.step_index));
        check_field("velocity", 48'(want.velocity), 48'(out_ch.data.velocity));
        check_field("acceleration", 48'(want.acceleration), 48'(out_ch.data.acceleration));
        check_field("step_displacement", 48'(want.step_displacement),
                    48'(out_ch.data.step_displacement));
        check_field("total_displacement", want.total_displacement,
                    out_ch.data.total_displacement);
        check_field("total_impulse", want.total_impulse, out_ch.data.total_impulse);
        check_field("step_work", 48'(want.step_work), 48'(out_ch.data.step_work));
        check_field("total_work", want.total_work, out_ch.data.total_work);
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // watchdog: any transfer on either channel restarts the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[vertical_drag_motion_step] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = vdms_pkg::REG_DRAG;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    failed = 1'b0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    // predictor starts at register reset values
    drag_k = 0;
    mass = 31'h1_0000;
    vel_init = 0;
    dt_ms = 31'h1_0000;
    interval_ms = 31'h1_0000;
    vel_now = 0;
    disp_total = 0;
    imp_total = 0;
    work_total = 0;
    phase_acc = 0;
    step_cnt = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_extremes();
    test_random_motion(0, 0, 85);
    test_random_motion(47, 0, 85);
    test_random_motion(0, 47, 85);
    test_random_motion(15, 15, 85);
    test_random_motion(0, 0, 85);
    test_random_motion(47, 0, 85);
    test_random_motion(0, 47, 85);
    test_random_motion(15, 15, 85);

    if (!failed) begin
      $display("[vertical_drag_motion_step] OK");
    end else begin
      $display("[vertical_drag_motion_step] ERROR");
    end
    $finish;
  end

endmodule

// File: vertical_drag_motion_step.f
hdl/vdms_pkg.sv
hdl/vdms_stream_if.sv
hdl/vdms_umd.sv
hdl/vertical_drag_motion_step.sv
sim/vertical_drag_motion_step_test.sv
